// ===== sv/lskv_pkg.sv =====
`timescale 1ns / 1ps
package lskv_pkg;

  // Default sizing of the bucket store
  localparam int unsigned NUM_BUCKETS_DEF = 1024;
  localparam int unsigned WAYS_DEF        = 4;
  localparam int unsigned VALUE_BITS_DEF  = 64;

  // Key hash constants
  localparam logic [31:0] SEED_RESET = 32'hdeadbeef;
  localparam logic [63:0] FH_M       = 64'h880355f21e6d1657;
  localparam logic [63:0] FH_MIX_MUL = 64'h2127599bf4325c37;
  localparam logic [63:0] FH_SEED_K  = FH_M << 3;

  // Request codes
  localparam logic [2:0] FUNC_READ   = 3'd0;
  localparam logic [2:0] FUNC_SET    = 3'd1;
  localparam logic [2:0] FUNC_INSERT = 3'd2;
  localparam logic [2:0] FUNC_GRANT  = 3'd3;
  localparam logic [2:0] FUNC_ACK    = 3'd4;

  // Reply codes
  localparam logic [2:0] KIND_PASS        = 3'd0;
  localparam logic [2:0] KIND_REJECT_READ = 3'd1;
  localparam logic [2:0] KIND_GRANT_READ  = 3'd2;
  localparam logic [2:0] KIND_REJECT_SET  = 3'd3;
  localparam logic [2:0] KIND_SILENT      = 3'd4;

  typedef struct packed {
    logic [2:0]  func;
    logic [63:0] req_key;
    logic [63:0] req_value;
    logic [31:0] req_version;
    logic [7:0]  fill_slot_in;
  } in_t;

  typedef struct packed {
    logic [2:0]  reply_kind;
    logic [63:0] reply_value;
    logic [31:0] reply_version;
    logic [7:0]  fill_slot_out;
  } out_t;

  typedef enum logic [2:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_HASH,
    ST_MOD,
    ST_RD,
    ST_LOAD,
    ST_SCAN,
    ST_WB
  } state_t;

endpackage

// ===== sv/locked_set_assoc_kv_cache.sv =====
`timescale 1ns / 1ps
// Steps from a taken request to its result: the hash (three 64-bit
// multiplies, three 32x32 products each on one multiplier), the bucket reduction (four
// folds, a reciprocal multiply, a back-multiply, one correction), the row read, the way
// scan and write-back. A stalled result holds the block in write-back.
// Requests are taken one at a time: a new one only after the last has left write-back.
// Reset: the store is first swept clear, one bucket row a cycle, before any request is taken.
module locked_set_assoc_kv_cache #(
  parameter int unsigned NUM_BUCKETS = lskv_pkg::NUM_BUCKETS_DEF,
  parameter int unsigned WAYS        = lskv_pkg::WAYS_DEF,
  parameter int unsigned VALUE_BITS  = lskv_pkg::VALUE_BITS_DEF
) (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           in_valid,
  output logic           in_stall,
  input  lskv_pkg::in_t  in_data,
  output logic           out_valid,
  input  logic           out_stall,
  output lskv_pkg::out_t out_data,
  input  logic           cfg_valid,
  output logic           cfg_ready,
  input  logic [31:0]    cfg_data
);
  import lskv_pkg::*;

  localparam int unsigned IW = (NUM_BUCKETS > 1) ? $clog2(NUM_BUCKETS) : 1;
  localparam int unsigned WI = (WAYS > 1) ? $clog2(WAYS) : 1;
  localparam logic [16:0]   NB_K    = 17'(NUM_BUCKETS);
  localparam logic [15:0]   R32_K   = 16'((64'd1 << 32) % 64'(NUM_BUCKETS));
  localparam logic [32:0]   RECIP_K = 33'((64'd1 << 32) / 64'(NUM_BUCKETS));
  localparam logic [IW-1:0] LAST_B  = IW'(NUM_BUCKETS - 1);
  localparam logic [WI-1:0] LAST_W  = WI'(WAYS - 1);
  localparam logic [7:0]    WAYS_K  = 8'(WAYS);

  typedef struct packed {
    logic                  valid;
    logic [63:0]           key;
    logic [VALUE_BITS-1:0] value;
    logic [31:0]           version;
  } way_t;

  typedef struct packed {
    logic                 lock;
    way_t [WAYS-1:0]      ways;
  } row_t;

  row_t store_mem [NUM_BUCKETS];

  state_t        state_r, state_nxt;
  in_t           req_r;
  logic [31:0]   seed_r;
  logic [IW-1:0] clr_r;
  logic [1:0]    mstep_r, stage_r;
  logic [63:0]   mul_a_r, acc_r, hash_r;
  logic [2:0]    mod_cnt_r;
  logic [31:0]   q_r;
  logic [16:0]   rr_r;
  logic [IW-1:0] rem_r;
  row_t          rd_row_r, row_r;
  logic [WI-1:0] idx_r, hit_idx_r, free_idx_r;
  logic          hit_r, free_r;
  logic          out_valid_r;
  out_t          out_r;

  logic [63:0]   mul_b, prod, mul_sum;
  logic [31:0]   opx, opy;
  logic [47:0]   fold_p;
  logic [63:0]   fold_v;
  logic [64:0]   bar_p;
  logic [32:0]   sub_p, diff;
  logic [16:0]   rem_fin;
  logic          rd_en, wr_en, out_free;
  logic [IW-1:0] wr_addr;
  row_t          wr_row, new_row;
  out_t          res;
  way_t          cur_way, fill_way;

  // Shared 32x32 multiplier, three partial products per 64-bit multiply
  always_comb begin
    mul_b   = (stage_r == 2'd1) ? FH_M : FH_MIX_MUL;
    opx     = (mstep_r == 2'd2) ? mul_a_r[63:32] : mul_a_r[31:0];
    opy     = (mstep_r == 2'd1) ? mul_b[63:32] : mul_b[31:0];
    prod    = 64'(opx) * 64'(opy);
    mul_sum = (mstep_r == 2'd0) ? prod : acc_r + {prod[31:0], 32'h0};
  end

  // Fold the hash below 2^32, then take the bucket by reciprocal multiply
  always_comb begin
    fold_p  = {16'h0, hash_r[63:32]} * {32'h0, R32_K};
    fold_v  = {16'h0, fold_p} + {32'h0, hash_r[31:0]};
    bar_p   = {33'h0, hash_r[31:0]} * {32'h0, RECIP_K};
    sub_p   = {1'b0, q_r} * {16'h0, NB_K};
    diff    = {1'b0, hash_r[31:0]} - sub_p;
    rem_fin = (rr_r >= NB_K) ? rr_r - NB_K : rr_r;
  end

  assign out_free = !out_valid_r || !out_stall;
  assign cur_way  = row_r.ways[idx_r];

  // Build the row to write back and the reply
  always_comb begin
    fill_way.valid   = 1'b1;
    fill_way.key     = req_r.req_key;
    fill_way.value   = req_r.req_value[VALUE_BITS-1:0];
    fill_way.version = req_r.req_version;
    new_row = row_r;
    res.reply_kind    = KIND_SILENT;
    res.reply_value   = 64'h0;
    res.reply_version = 32'h0;
    res.fill_slot_out = 8'h0;
    case (req_r.func)
      FUNC_READ, FUNC_SET, FUNC_INSERT: begin
        if (row_r.lock) begin
          res.reply_kind = (req_r.func == FUNC_READ) ? KIND_REJECT_READ : KIND_REJECT_SET;
        end else begin
          new_row.lock   = 1'b1;
          res.reply_kind = KIND_PASS;
          if (req_r.func == FUNC_READ) begin
            if (hit_r) begin
              res.reply_kind    = KIND_GRANT_READ;
              res.reply_value   = 64'(row_r.ways[hit_idx_r].value);
              res.reply_version = row_r.ways[hit_idx_r].version;
              new_row.lock      = 1'b0;
            end else if (free_r) begin
              res.fill_slot_out = 8'(free_idx_r);
            end
          end else if (req_r.func == FUNC_SET) begin
            if (hit_r) begin
              new_row.ways[hit_idx_r].valid = 1'b0;
            end
          end else if (free_r) begin
            new_row.ways[free_idx_r] = fill_way;
          end
        end
      end
      FUNC_GRANT: begin
        if (req_r.fill_slot_in < WAYS_K) begin
          new_row.ways[req_r.fill_slot_in[WI-1:0]] = fill_way;
          new_row.lock = 1'b0;
        end
      end
      FUNC_ACK: begin
        new_row.lock = 1'b0;
      end
      default: begin
      end
    endcase
  end

  // Next state
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      ST_CLEAR: if (clr_r == LAST_B) state_nxt = ST_IDLE;
      ST_IDLE:  if (in_valid) state_nxt = ST_HASH;
      ST_HASH:  if (mstep_r == 2'd2 && stage_r == 2'd2) state_nxt = ST_MOD;
      ST_MOD:   if (mod_cnt_r == 3'd6) state_nxt = ST_RD;
      ST_RD:    state_nxt = ST_LOAD;
      ST_LOAD:  state_nxt = ST_SCAN;
      ST_SCAN:  if (idx_r == LAST_W) state_nxt = ST_WB;
      ST_WB:    if (out_free) state_nxt = ST_IDLE;
      default:  state_nxt = ST_CLEAR;
    endcase
  end

  // Control outputs per state
  always_comb begin
    in_stall = 1'b1;
    rd_en    = 1'b0;
    wr_en    = 1'b0;
    wr_addr  = rem_r;
    wr_row   = new_row;
    case (state_r)
      ST_CLEAR: begin
        wr_en   = 1'b1;
        wr_addr = clr_r;
        wr_row  = '0;
      end
      ST_IDLE: in_stall = 1'b0;
      ST_RD:   rd_en = 1'b1;
      ST_WB:   wr_en = out_free;
      default: begin
      end
    endcase
  end

  // Bucket store
  always_ff @(posedge clk) begin
    if (wr_en) begin
      store_mem[wr_addr] <= wr_row;
    end
    if (rd_en) begin
      rd_row_r <= store_mem[rem_r];
    end
  end

  // Control state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_CLEAR;
      clr_r       <= '0;
      seed_r      <= SEED_RESET;
      out_valid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      if (state_r == ST_CLEAR) begin
        clr_r <= clr_r + 1'b1;
      end
      if (cfg_valid) begin
        seed_r <= cfg_data;
      end
      if (state_r == ST_WB && out_free) begin
        out_valid_r <= 1'b1;
      end else if (!out_stall) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  // Datapath: hash, reduce, scan, result
  always_ff @(posedge clk) begin
    case (state_r)
      ST_IDLE: begin
        req_r   <= in_data;
        mul_a_r <= in_data.req_key ^ (in_data.req_key >> 23);
        mstep_r <= 2'd0;
        stage_r <= 2'd0;
      end
      ST_HASH: begin
        acc_r <= mul_sum;
        if (mstep_r == 2'd2) begin
          mstep_r <= 2'd0;
          stage_r <= stage_r + 2'd1;
          if (stage_r == 2'd0) begin
            mul_a_r <= FH_SEED_K ^ {32'h0, seed_r} ^ mul_sum ^ (mul_sum >> 47);
          end else if (stage_r == 2'd1) begin
            mul_a_r <= mul_sum ^ (mul_sum >> 23);
          end else begin
            hash_r    <= mul_sum ^ (mul_sum >> 47);
            mod_cnt_r <= 3'd0;
          end
        end else begin
          mstep_r <= mstep_r + 2'd1;
        end
      end
      ST_MOD: begin
        if (mod_cnt_r < 3'd4) begin
          hash_r <= fold_v;
        end else if (mod_cnt_r == 3'd4) begin
          q_r <= bar_p[63:32];
        end else if (mod_cnt_r == 3'd5) begin
          rr_r <= diff[16:0];
        end else begin
          rem_r <= rem_fin[IW-1:0];
        end
        mod_cnt_r <= mod_cnt_r + 3'd1;
      end
      ST_LOAD: begin
        row_r  <= rd_row_r;
        idx_r  <= '0;
        hit_r  <= 1'b0;
        free_r <= 1'b0;
        hit_idx_r  <= '0;
        free_idx_r <= '0;
      end
      ST_SCAN: begin
        if (!hit_r && cur_way.valid && cur_way.key == req_r.req_key) begin
          hit_r     <= 1'b1;
          hit_idx_r <= idx_r;
        end
        if (!free_r && !cur_way.valid) begin
          free_r     <= 1'b1;
          free_idx_r <= idx_r;
        end
        idx_r <= idx_r + 1'b1;
      end
      ST_WB: begin
        if (out_free) begin
          out_r <= res;
        end
      end
      default: begin
      end
    endcase
  end

  assign cfg_ready = 1'b1;
  assign out_valid = out_valid_r;
  assign out_data  = out_r;

endmodule
